// ----- hw/rtl/vfq_pkg.sv -----
// ----------------------------------------------------------------------------
// vfq_pkg
// Types and codes shared by the video frame queue with group-of-pictures
// discard.
// ----------------------------------------------------------------------------
package vfq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;

  // Request codes
  localparam logic [2:0] REQ_PUT     = 3'd0;
  localparam logic [2:0] REQ_GET     = 3'd1;
  localparam logic [2:0] REQ_DISCARD = 3'd2;
  localparam logic [2:0] REQ_FLUSH   = 3'd3;
  localparam logic [2:0] REQ_ABORT   = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABORTED = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NONPIC  = 3'd4;

  // NAL unit types
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] packet_handle;
    logic [4:0]  nal_type;
    logic [15:0] frame_duration;
    logic [31:0] frame_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [4:0]  out_nal_type;
    logic [15:0] out_duration;
    logic [31:0] out_time;
    logic [6:0]  dropped_count;
    logic [21:0] dropped_duration;
    logic [6:0]  queue_level;
  } res_t;

  // One stored frame descriptor
  typedef struct packed {
    logic [15:0] handle;
    logic [4:0]  nal;
    logic [15:0] duration;
    logic [31:0] stamp;
  } slot_t;

endpackage

// ----- hw/rtl/vfq_mem.sv -----
// ----------------------------------------------------------------------------
// vfq_mem
// Descriptor store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vfq_mem #(
  parameter int QUEUE_DEPTH = vfq_pkg::DEF_QUEUE_DEPTH,
  parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  vfq_pkg::slot_t        wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output vfq_pkg::slot_t        rd_data
);
  import vfq_pkg::*;

  slot_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/vfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// vfq_ctrl
// Request sequencer: queue pointers, abort and rebase state, and the walk
// that removes head frames for a group-of-pictures discard.
// ----------------------------------------------------------------------------
module vfq_ctrl #(
  parameter int QUEUE_DEPTH = vfq_pkg::DEF_QUEUE_DEPTH,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  vfq_pkg::req_t        req,
  output logic                 req_ready,
  input  logic                 out_free,
  output logic                 res_load,
  output vfq_pkg::res_t        result,
  output logic                 wr_en,
  output logic [PTR_W-1:0]     wr_addr,
  output vfq_pkg::slot_t       wr_data,
  output logic [PTR_W-1:0]     rd_addr,
  input  vfq_pkg::slot_t       rd_data
);
  import vfq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GET  = 2'd1;
  localparam logic [1:0] S_DISC = 2'd2;

  logic [1:0]       state, state_next;
  logic [PTR_W-1:0] head_ptr, head_ptr_next;
  logic [PTR_W-1:0] tail_ptr, tail_ptr_next;
  logic [LVL_W-1:0] level, level_next;
  logic             aborted, aborted_next;
  logic             rebase_valid, rebase_valid_next;
  logic [31:0]      rebase_time, rebase_time_next;
  logic             disc_first, disc_first_next;
  logic [LVL_W-1:0] drop_cnt, drop_cnt_next;
  logic [21:0]      drop_dur, drop_dur_next;

  logic             accept;
  logic [PTR_W-1:0] pop_head;
  logic [PTR_W-1:0] pop_tail;
  logic [PTR_W-1:0] tail_inc;
  logic             is_full;

  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign is_full   = (level == LVL_W'(QUEUE_DEPTH));

  assign tail_inc = (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;

  // Removing the last frame returns both pointers to slot zero.
  always_comb begin
    if (level == LVL_W'(1)) begin
      pop_head = '0;
      pop_tail = '0;
    end else begin
      pop_head = (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
      pop_tail = tail_ptr;
    end
  end

  assign wr_addr = tail_ptr;
  assign wr_data = '{handle: req.packet_handle, nal: req.nal_type,
                     duration: req.frame_duration, stamp: req.frame_time};

  // The head slot is read every cycle at the pointer that the next cycle will
  // hold. A put only writes at its own transfer, and the next request is read
  // again at its own transfer, so a read never needs data written at the same
  // edge.
  assign rd_addr = head_ptr_next;

  always_comb begin
    state_next        = state;
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    level_next        = level;
    aborted_next      = aborted;
    rebase_valid_next = rebase_valid;
    rebase_time_next  = rebase_time;
    disc_first_next   = disc_first;
    drop_cnt_next     = drop_cnt;
    drop_dur_next     = drop_dur;
    wr_en             = 1'b0;
    res_load          = 1'b0;
    result            = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_PUT: begin
              res_load = 1'b1;
              if (aborted) begin
                result.status = ST_ABORTED;
              end else if (is_full) begin
                result.status = ST_FULL;
              end else begin
                wr_en         = 1'b1;
                tail_ptr_next = tail_inc;
                level_next    = level + 1'b1;
              end
            end
            REQ_GET: begin
              if (aborted) begin
                res_load      = 1'b1;
                result.status = ST_ABORTED;
              end else if (level == '0) begin
                res_load      = 1'b1;
                result.status = ST_EMPTY;
              end else begin
                state_next = S_GET;
              end
            end
            REQ_DISCARD: begin
              if (aborted) begin
                res_load      = 1'b1;
                result.status = ST_ABORTED;
              end else if (level == '0) begin
                res_load = 1'b1;
              end else begin
                state_next      = S_DISC;
                disc_first_next = 1'b1;
                drop_cnt_next   = '0;
                drop_dur_next   = '0;
              end
            end
            REQ_FLUSH: begin
              res_load      = 1'b1;
              head_ptr_next = '0;
              tail_ptr_next = '0;
              level_next    = '0;
            end
            REQ_ABORT: begin
              res_load     = 1'b1;
              aborted_next = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_GET: begin
        res_load            = 1'b1;
        result.out_handle   = rd_data.handle;
        result.out_nal_type = rd_data.nal;
        result.out_duration = rd_data.duration;
        if (rebase_valid) begin
          result.out_time  = rebase_time;
          rebase_time_next = rebase_time + 32'(rd_data.duration);
        end else begin
          result.out_time = rd_data.stamp;
        end
        head_ptr_next = pop_head;
        tail_ptr_next = pop_tail;
        level_next    = level - 1'b1;
        state_next    = S_IDLE;
      end

      S_DISC: begin
        if (level == '0) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          if (!rebase_valid) begin
            rebase_valid_next = 1'b1;
            rebase_time_next  = rd_data.stamp;
          end
          disc_first_next = 1'b0;
          if ((rd_data.nal == NAL_IDR && !disc_first) ||
              (rd_data.nal != NAL_IDR && rd_data.nal != NAL_NON_IDR)) begin
            // The frame that ends the walk stays in the queue.
            res_load   = 1'b1;
            state_next = S_IDLE;
            if (rd_data.nal != NAL_IDR) begin
              result.status = ST_NONPIC;
            end
          end else begin
            drop_cnt_next = drop_cnt + 1'b1;
            drop_dur_next = drop_dur + 22'(rd_data.duration);
            head_ptr_next = pop_head;
            tail_ptr_next = pop_tail;
            level_next    = level - 1'b1;
          end
        end
        result.dropped_count    = 7'(drop_cnt);
        result.dropped_duration = drop_dur;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    result.queue_level = 7'(level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      level        <= '0;
      aborted      <= 1'b0;
      rebase_valid <= 1'b0;
      rebase_time  <= '0;
      disc_first   <= 1'b0;
      drop_cnt     <= '0;
      drop_dur     <= '0;
    end else begin
      state        <= state_next;
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      level        <= level_next;
      aborted      <= aborted_next;
      rebase_valid <= rebase_valid_next;
      rebase_time  <= rebase_time_next;
      disc_first   <= disc_first_next;
      drop_cnt     <= drop_cnt_next;
      drop_dur     <= drop_dur_next;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    level == '0 |-> head_ptr == '0 && tail_ptr == '0)
    else $error("empty queue with pointers away from slot zero");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result produced while output register is occupied");

  a_get_from_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_GET |-> $past(accept) && level != '0)
    else $error("get read cycle without an accepted get on a filled queue");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    state == S_DISC && disc_first |-> level != '0 && !aborted)
    else $error("discard walk started on an empty or aborted queue");

endmodule

// ----- hw/rtl/video_frame_queue_gop_drop_top.sv -----
// ----------------------------------------------------------------------------
// video_frame_queue_gop_drop_top
// Bounded queue of video frame descriptors with group-of-pictures discard.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (req_valid, req_stall, req) and each one
// yields exactly one result on the res channel (res_valid, res_stall, res).
// A transfer happens at a rising edge with valid high and stall low.
// Put, flush, abort, unused codes, and any get or discard refused as aborted
// or empty load their result into the output register at the request
// transfer; a new request can be taken once that register is free.
// A get that returns a frame passes through the S_GET state, since the head
// descriptor comes out of the memory's registered read port.
// A discard that walks the queue removes one head frame per cycle in the
// S_DISC state and gives its result from a last S_DISC step, whether it stops
// at a frame or at an empty queue.
// The request channel is stalled while a get or a discard is in progress.
// Results sit in one output register; the block takes a request only if it is
// empty or if the request's result can be written as the held one
// leaves. Reset empties the queue and clears the abort and rebase state; the
// descriptor memory is not cleared, since only written slots are read.
// ----------------------------------------------------------------------------
module video_frame_queue_gop_drop_top #(
  parameter int QUEUE_DEPTH = vfq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  vfq_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output vfq_pkg::res_t  res
);
  import vfq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic             req_ready;
  logic             out_free;
  logic             res_load;
  res_t             result;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  slot_t            wr_data;
  logic [PTR_W-1:0] rd_addr;
  slot_t            rd_data;

  assign req_stall = !req_ready;
  assign out_free  = !res_valid || !res_stall;

  vfq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .LVL_W       (LVL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_free  (out_free),
    .res_load  (res_load),
    .result    (result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  vfq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_W      (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= result;
    end
  end

endmodule

// ----- test/vfq_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfq_result_checker
// Watches both channels of the video frame queue, keeps its own copy of the
// queue, the abort flag and the rebase clock, and compares every result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module vfq_result_checker #(
  parameter int QUEUE_DEPTH = vfq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  vfq_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  vfq_pkg::res_t res,
  output int            fail_count,
  output int            results_pending,
  output int            results_checked
);
  import vfq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  slot_t       frames [QUEUE_DEPTH];
  int          head_idx;
  int          tail_idx;
  int          held;
  logic        aborted;
  logic        rebase_on;
  logic [31:0] rebase_stamp;
  res_t        awaited_results [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int index);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                index, name, got, want));
    end
  endtask

  task automatic drop_head();
    head_idx = (head_idx + 1) % QUEUE_DEPTH;
    held--;
    // An emptied queue restarts both pointers at slot zero.
    if (held == 0) begin
      head_idx = 0;
      tail_idx = 0;
    end
  endtask

  // Applies one request to the local copy of the queue and returns the result
  // that the block must give for it.
  task automatic advance_frame_queue(input req_t r, output res_t y);
    logic        leading_idr;
    logic [21:0] drop_sum;
    logic [6:0]  drop_cnt;
    slot_t       head_frame;
    y        = '0;
    drop_sum = '0;
    drop_cnt = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (aborted) begin
          y.status = ST_ABORTED;
        end else if (held >= QUEUE_DEPTH) begin
          y.status = ST_FULL;
        end else begin
          frames[IDX_W'(tail_idx)] = '{r.packet_handle, r.nal_type, r.frame_duration,
                                       r.frame_time};
          tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
          held++;
        end
      end
      REQ_GET: begin
        if (aborted) begin
          y.status = ST_ABORTED;
        end else if (held == 0) begin
          y.status = ST_EMPTY;
        end else begin
          head_frame     = frames[IDX_W'(head_idx)];
          y.out_handle   = head_frame.handle;
          y.out_nal_type = head_frame.nal;
          y.out_duration = head_frame.duration;
          y.out_time     = head_frame.stamp;
          if (rebase_on) begin
            y.out_time   = rebase_stamp;
            rebase_stamp = rebase_stamp + 32'(head_frame.duration);
          end
          drop_head();
        end
      end
      REQ_DISCARD: begin
        if (aborted) begin
          y.status = ST_ABORTED;
        end else begin
          // An IDR frame at the head opens the group being dropped; the next
          // IDR frame closes it.
          leading_idr = (held > 0) && (frames[IDX_W'(head_idx)].nal == NAL_IDR);
          while (held > 0) begin
            head_frame = frames[IDX_W'(head_idx)];
            if (!rebase_on) begin
              rebase_on    = 1'b1;
              rebase_stamp = head_frame.stamp;
            end
            if (head_frame.nal == NAL_IDR) begin
              if (!leading_idr) break;
              leading_idr = 1'b0;
            end else if (head_frame.nal != NAL_NON_IDR) begin
              y.status = ST_NONPIC;
              break;
            end
            drop_sum = drop_sum + 22'(head_frame.duration);
            drop_cnt = drop_cnt + 7'd1;
            drop_head();
          end
        end
        y.dropped_count    = drop_cnt;
        y.dropped_duration = drop_sum;
      end
      REQ_FLUSH: begin
        head_idx = 0;
        tail_idx = 0;
        held     = 0;
      end
      REQ_ABORT: aborted = 1'b1;
      default: ;
    endcase
    y.queue_level = 7'(held);
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      head_idx     = 0;
      tail_idx     = 0;
      held         = 0;
      aborted      = 1'b0;
      rebase_on    = 1'b0;
      rebase_stamp = '0;
      awaited_results.delete();
    end else begin
      // A result can never belong to a request taken at the same edge, so
      // results are matched before the new request is predicted.
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(res.status), 32'(want.status), results_checked);
          check_field("out_handle", 32'(res.out_handle), 32'(want.out_handle),
                      results_checked);
          check_field("out_nal_type", 32'(res.out_nal_type), 32'(want.out_nal_type),
                      results_checked);
          check_field("out_duration", 32'(res.out_duration), 32'(want.out_duration),
                      results_checked);
          check_field("out_time", res.out_time, want.out_time, results_checked);
          check_field("dropped_count", 32'(res.dropped_count), 32'(want.dropped_count),
                      results_checked);
          check_field("dropped_duration", 32'(res.dropped_duration),
                      32'(want.dropped_duration), results_checked);
          check_field("queue_level", 32'(res.queue_level), 32'(want.queue_level),
                      results_checked);
        end
        results_checked++;
      end
      if (req_valid && !req_stall) begin
        advance_frame_queue(req, want);
        awaited_results.push_back(want);
      end
    end
    results_pending = awaited_results.size();
  end

endmodule

// ----- test/video_frame_queue_gop_drop_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_frame_queue_gop_drop_top_tb
// Drives requests into the video frame queue and absorbs its results with
// random gaps and stalls. A directed opening covers empty, rebase, discard
// and non-picture cases; random groups of pictures follow, with puts that fill
// the queue under one long output hold-off; an aborted tail closes the run.
// ----------------------------------------------------------------------------
module video_frame_queue_gop_drop_top_tb;
  import vfq_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  int   fail_count;
  int   results_pending;
  int   results_checked;
  int   items_sent  = 0;
  int   idle_cycles = 0;
  logic sender_gaps_on     = 1'b1;
  logic receiver_stalls_on = 1'b1;
  logic hold_output        = 1'b0;

  always #1 clk = ~clk;

  video_frame_queue_gop_drop_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  vfq_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res             (res),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic req_t frame_put(input logic [15:0] handle, input logic [4:0] nal,
                                     input logic [15:0] dur, input logic [31:0] stamp);
    req_t r;
    r.req_type       = REQ_PUT;
    r.packet_handle  = handle;
    r.nal_type       = nal;
    r.frame_duration = dur;
    r.frame_time     = stamp;
    return r;
  endfunction

  function automatic req_t random_put(input logic [4:0] nal);
    return frame_put(16'($urandom), nal, 16'($urandom), $urandom);
  endfunction

  // Non-put requests still carry random payload fields, which must be ignored.
  function automatic req_t command(input logic [2:0] code);
    req_t r;
    r          = random_put(5'($urandom_range(0, 31)));
    r.req_type = code;
    return r;
  endfunction

  // Must be called at a falling edge; returns at the falling edge after the
  // transfer, leaving valid high so back-to-back items need no extra step.
  task automatic send_request(input req_t item);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Result side: a random stall before each transfer, or one long hold-off
  // when the stimulus asks for it.
  initial begin : receiver
    int stall_len;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        stall_len = receiver_stalls_on ? $urandom_range(0, 15) : 0;
        if (stall_len > 0) begin
          res_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int   scenario;
    int   n;
    logic pressure_done;
    pressure_done = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening.
    send_request(command(REQ_GET));
    send_request(command(REQ_DISCARD));
    send_request(frame_put(16'hFFFF, NAL_IDR, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(frame_put(16'h0000, NAL_NON_IDR, 16'h0000, 32'h0000_0000));
    send_request(frame_put(16'h1234, NAL_NON_IDR, 16'h8000, 32'h0000_0064));
    send_request(random_put(NAL_IDR));
    send_request(random_put(NAL_NON_IDR));
    send_request(command(REQ_GET));
    // Drops the two non-IDR frames, stops at the IDR and latches the rebase.
    send_request(command(REQ_DISCARD));
    send_request(random_put(NAL_IDR));
    send_request(random_put(NAL_NON_IDR));
    send_request(random_put(5'd31));
    send_request(command(REQ_GET));
    send_request(command(REQ_GET));
    // Head IDR and one non-IDR go, then the walk stops at the non-picture.
    send_request(command(REQ_DISCARD));
    send_request(command(REQ_DISCARD));
    send_request(command(REQ_GET));
    send_request(random_put(NAL_IDR));
    send_request(random_put(NAL_IDR));
    send_request(command(REQ_DISCARD));
    send_request(command(REQ_FLUSH));
    send_request(command(3'd5));
    send_request(command(3'd6));
    send_request(command(3'd7));

    // Random groups of pictures mixed with gets, discards and noise.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        sender_gaps_on     = ($urandom_range(0, 2) != 0);
        receiver_stalls_on = ($urandom_range(0, 2) != 0);
      end
      if (!pressure_done && items_sent >= RANDOM_ITEMS / 2) begin
        // Long output hold-off while puts keep coming: the block backs up,
        // and the queue runs full.
        pressure_done = 1'b1;
        send_request(command(REQ_FLUSH));
        hold_output    = 1'b1;
        sender_gaps_on = 1'b0;
        repeat (70) begin
          send_request(random_put(($urandom_range(0, 7) == 0) ? NAL_IDR : NAL_NON_IDR));
        end
        repeat (12) send_request(command(REQ_GET));
        sender_gaps_on = 1'b1;
      end
      scenario = $urandom_range(0, 19);
      if (scenario <= 8) begin
        send_request(random_put(NAL_IDR));
        n = $urandom_range(0, 10);
        repeat (n) begin
          send_request(random_put(($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                              : NAL_NON_IDR));
        end
      end else if (scenario <= 13) begin
        n = $urandom_range(1, 8);
        repeat (n) send_request(command(REQ_GET));
      end else if (scenario <= 16) begin
        send_request(command(REQ_DISCARD));
      end else if (scenario == 17) begin
        send_request(command(REQ_FLUSH));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(command(3'($urandom_range(0, 7))));
      end
    end

    // After an abort, puts, gets and discards are refused; a flush is not.
    send_request(command(REQ_ABORT));
    send_request(random_put(NAL_IDR));
    send_request(command(REQ_GET));
    send_request(command(REQ_DISCARD));
    send_request(command(REQ_FLUSH));
    send_request(command(REQ_GET));
    req_valid <= 1'b0;

    while (results_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d requests and checked %0d results.", items_sent, results_checked);
    $display("Run covered groups of pictures, discards with rebase, a full queue under");
    $display("output hold-off, noise request codes and requests after abort.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
